[rtl/core/column_width_unpacker_unit_macros.svh]
// Assertion macros used by the column width unpacker checker.
`ifndef COLUMN_WIDTH_UNPACKER_UNIT_MACROS_SVH
`define COLUMN_WIDTH_UNPACKER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CWU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CWU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/cwu_pkg.sv]
// Shared constants and controller/datapath types of the column width unpacker.
package cwu_pkg;

   localparam int LANES       = 16;
   localparam int WORD_BITS   = 32;
   localparam int LANE_BITS   = 4;
   localparam int COLUMN_BITS = 5;
   localparam int POS_BITS    = $clog2(LANES + 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // take the word on the request channel
      logic step;     // scan one selector bit
   } cwu_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic expect_selector;  // next word is a selector
      logic selector_zero;    // stored selector has no set bit
      logic bit_closes;       // current selector bit closes a column
      logic rest_zero;        // no set selector bit above the current one
      logic out_busy;         // result register holds an untaken transaction
   } cwu_status_type;

endpackage

[rtl/core/cwu_req_if.sv]
// Request channel: one packed stream word per transaction.
interface cwu_req_if
   import cwu_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] stream_word;

   modport source (output valid, output stream_word, input ready);
   modport sink (input valid, input stream_word, output ready);
   modport monitor (input valid, input stream_word, input ready);
endinterface

[rtl/core/cwu_rsp_if.sv]
// Response channel: one decoded integer with its lane and column per transaction.
interface cwu_rsp_if
   import cwu_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [WORD_BITS-1:0]   value;
   logic [LANE_BITS-1:0]   lane;
   logic [COLUMN_BITS-1:0] column;
   logic                   last;

   modport source (output valid, output value, output lane, output column,
                   output last, input ready);
   modport sink (input valid, input value, input lane, input column,
                 input last, output ready);
   modport monitor (input valid, input value, input lane, input column,
                    input last, input ready);
endinterface

[rtl/core/cwu_controller.sv]
// Controller: sequences word intake and the bit-by-bit selector scan.
module cwu_controller
   import cwu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  cwu_status_type status,
   output cwu_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      stall;

   // Hold the scan while a closing bit finds the result register occupied.
   assign stall = status.bit_closes && status.out_busy;

   // Decode commands and next state.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.step   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && !status.expect_selector && !status.selector_zero) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = !stall;
            if (!stall && status.rest_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/cwu_datapath.sv]
// Datapath: selector and word position, scan shifters, value builder, result register.
module cwu_datapath
   import cwu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cwu_cmd_type            cmd,
   output cwu_status_type         status,
   input  logic [WORD_BITS-1:0]   req_stream_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_BITS-1:0]   rsp_value,
   output logic [LANE_BITS-1:0]   rsp_lane,
   output logic [COLUMN_BITS-1:0] rsp_column,
   output logic                   rsp_last
);

   logic [WORD_BITS-1:0]   selector_ff,  selector_in;
   logic [POS_BITS-1:0]    position_ff,  position_in;
   logic [LANE_BITS-1:0]   lane_ff,      lane_in;
   logic [WORD_BITS-1:0]   scan_sel_ff,  scan_sel_in;
   logic [WORD_BITS-1:0]   scan_pay_ff,  scan_pay_in;
   logic [WORD_BITS-1:0]   bit_pos_ff,   bit_pos_in;
   logic [WORD_BITS-1:0]   acc_ff,       acc_in;
   logic [COLUMN_BITS-1:0] column_ff,    column_in;
   logic                   out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0]   out_value_ff, out_value_in;
   logic [LANE_BITS-1:0]   out_lane_ff,  out_lane_in;
   logic [COLUMN_BITS-1:0] out_col_ff,   out_col_in;
   logic                   out_last_ff,  out_last_in;
   logic [WORD_BITS-1:0]   acc_next;
   logic                   emit;

   // Report status to the controller.
   assign status.expect_selector = (position_ff == '0);
   assign status.selector_zero   = (selector_ff == '0);
   assign status.bit_closes      = scan_sel_ff[0];
   assign status.rest_zero       = (scan_sel_ff[WORD_BITS-1:1] == '0);
   assign status.out_busy        = out_valid_ff && !rsp_ready;

   // Merge the current payload bit into the column value.
   assign acc_next = acc_ff | (bit_pos_ff & {WORD_BITS{scan_pay_ff[0]}});
   assign emit     = cmd.step && scan_sel_ff[0];

   // Load words, shift the scan registers and fill the result register.
   always_comb begin
      selector_in  = selector_ff;
      position_in  = position_ff;
      lane_in      = lane_ff;
      scan_sel_in  = scan_sel_ff;
      scan_pay_in  = scan_pay_ff;
      bit_pos_in   = bit_pos_ff;
      acc_in       = acc_ff;
      column_in    = column_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_lane_in  = out_lane_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;

      if (cmd.accept) begin
         if (position_ff == '0) begin
            selector_in = req_stream_word;
            position_in = POS_BITS'(1);
         end else begin
            lane_in     = LANE_BITS'(position_ff - POS_BITS'(1));
            position_in = (position_ff == POS_BITS'(LANES)) ? '0
                                                            : position_ff + POS_BITS'(1);
            scan_sel_in = selector_ff;
            scan_pay_in = req_stream_word;
            bit_pos_in  = WORD_BITS'(1);
            acc_in      = '0;
            column_in   = '0;
         end
      end

      if (cmd.step) begin
         scan_sel_in = scan_sel_ff >> 1;
         scan_pay_in = scan_pay_ff >> 1;
         if (emit) begin
            acc_in     = '0;
            bit_pos_in = WORD_BITS'(1);
            column_in  = column_ff + COLUMN_BITS'(1);
         end else begin
            acc_in     = acc_next;
            bit_pos_in = bit_pos_ff << 1;
         end
      end

      if (emit) begin
         out_valid_in = 1'b1;
         out_value_in = acc_next;
         out_lane_in  = lane_ff;
         out_col_in   = column_ff;
         out_last_in  = (scan_sel_ff[WORD_BITS-1:1] == '0);
      end
   end

   // Clear control state under reset; payload registers run free.
   always_ff @(posedge clock) begin
      if (reset) begin
         selector_ff  <= '0;
         position_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         selector_ff  <= selector_in;
         position_ff  <= position_in;
         out_valid_ff <= out_valid_in;
      end
      lane_ff      <= lane_in;
      scan_sel_ff  <= scan_sel_in;
      scan_pay_ff  <= scan_pay_in;
      bit_pos_ff   <= bit_pos_in;
      acc_ff       <= acc_in;
      column_ff    <= column_in;
      out_value_ff <= out_value_in;
      out_lane_ff  <= out_lane_in;
      out_col_ff   <= out_col_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_lane   = out_lane_ff;
   assign rsp_column = out_col_ff;
   assign rsp_last   = out_last_ff;

endmodule

[rtl/core/column_width_unpacker_unit.sv]
// Column width unpacker: top level joining controller and datapath.
//
// The block takes a codeword of 17 words: a 32-bit selector whose set bits
// close columns, then 16 lane payload words. A selector word is taken and
// gives no result. A payload word is taken, after which the selector is
// scanned one bit per cycle, except while the scan stalls, up to its highest
// set bit; with a zero selector no scan follows and the word gives no result.
// Each closed column sends one transaction on the response channel (value,
// lane, column, last set on the final column of the word). A column-closing
// bit stalls the scan while a finished result waits in the one-entry response
// register and is not taken; the next request word is accepted as soon as the
// scan ends, even while the last result still waits to be taken.
module column_width_unpacker_unit
   import cwu_pkg::*;
(
   input logic clock,
   input logic reset,
   cwu_req_if.sink   req_port,
   cwu_rsp_if.source rsp_port
);

   cwu_cmd_type    cmd;
   cwu_status_type status;

   cwu_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cwu_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_stream_word (req_port.stream_word),
      .rsp_valid       (rsp_port.valid),
      .rsp_ready       (rsp_port.ready),
      .rsp_value       (rsp_port.value),
      .rsp_lane        (rsp_port.lane),
      .rsp_column      (rsp_port.column),
      .rsp_last        (rsp_port.last)
   );

endmodule

[rtl/core/cwu_checker.sv]
// Port-level checker for the column width unpacker, bound to the top level.
`include "column_width_unpacker_unit_macros.svh"

module cwu_checker
   import cwu_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [WORD_BITS-1:0]   rsp_value,
   input logic [LANE_BITS-1:0]   rsp_lane,
   input logic [COLUMN_BITS-1:0] rsp_column,
   input logic                   rsp_last
);

   logic                                     rsp_stall;
   logic [WORD_BITS+LANE_BITS+COLUMN_BITS:0] rsp_data;

   // Gather the response payload and its stall condition.
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_data  = {rsp_value, rsp_lane, rsp_column, rsp_last};

   // Come out of reset idle with no pending result.
   `CWU_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "not idle after reset")

   // Hold a stalled result unchanged.
   `CWU_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data), "result changed")

   // A payload word still being scanned blocks new requests.
   `CWU_ASSERT_NOW(a_scan_busy, clock, reset, rsp_valid && !rsp_last, !req_ready, "ready during scan")

endmodule

bind column_width_unpacker_unit cwu_checker u_cwu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_value  (rsp_port.value),
   .rsp_lane   (rsp_port.lane),
   .rsp_column (rsp_port.column),
   .rsp_last   (rsp_port.last)
);
